// File: design/hex_cell_corner_indices_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hex cell corner index block
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef HEX_CELL_CORNER_INDICES_TOP_MACROS_SVH
`define HEX_CELL_CORNER_INDICES_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HCCI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HCCI_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hcci_pkg.sv
// ----------------------------------------------------------------------------
// hcci_pkg
// Widths, register indices and helpers for the hex cell corner index block.
// ----------------------------------------------------------------------------
package hcci_pkg;

  localparam int IDX_W     = 30;  // linear cell index
  localparam int CFG_W     = 11;  // axis size registers
  localparam int CFG_IDX_W = 2;   // config register index
  localparam int CORNER_W  = 31;  // vertex index

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_I = 2'd0,
    REG_CELLS_J = 2'd1,
    REG_CELLS_K = 2'd2
  } cfg_reg_t;

  // Axis size as used: zero reads as one, large values saturate at vmax
  function automatic logic [CFG_W-1:0] clamp_axis(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] vmax);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > vmax) begin
      r = vmax;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: design/hcci_div_pipe.sv
// ----------------------------------------------------------------------------
// hcci_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module hcci_div_pipe #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 22,
  parameter int Q_W   = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic             out_vld,
  output logic [Q_W-1:0]   out_quo,
  output logic [NUM_W-1:0] out_rem
);

  // trial subtrahend needs room for the divisor shifted by the top quotient bit
  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             vld_r [Q_W];
  logic [NUM_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];

  genvar s;
  generate
    for (s = 0; s < Q_W; s++) begin : g_stage
      logic             vld_prev;
      logic [NUM_W-1:0] rem_prev;
      logic [Q_W-1:0]   quo_prev;
      logic [DEN_W-1:0] den_prev;
      logic [CW-1:0]    trial;
      logic             fits;
      logic [NUM_W-1:0] rem_nxt;
      logic [Q_W-1:0]   quo_nxt;

      if (s == 0) begin : g_head
        assign vld_prev = in_vld;
        assign rem_prev = in_num;
        assign quo_prev = '0;
        assign den_prev = in_den;
      end else begin : g_body
        assign vld_prev = vld_r[s-1];
        assign rem_prev = rem_r[s-1];
        assign quo_prev = quo_r[s-1];
        assign den_prev = den_r[s-1];
      end

      // one restoring step: subtract the shifted divisor if it fits
      always_comb begin
        trial   = CW'(den_prev) << (Q_W - 1 - s);
        fits    = CW'(rem_prev) >= trial;
        rem_nxt = fits ? NUM_W'(CW'(rem_prev) - trial) : rem_prev;
        quo_nxt = quo_prev;
        quo_nxt[Q_W-1-s] = fits;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else begin
          vld_r[s] <= vld_prev;
        end
      end

      always_ff @(posedge clk) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
        den_r[s] <= den_prev;
      end
    end
  endgenerate

  assign out_vld = vld_r[Q_W-1];
  assign out_quo = quo_r[Q_W-1];
  assign out_rem = rem_r[Q_W-1];

endmodule

// File: design/hex_cell_corner_indices_top.sv
// ----------------------------------------------------------------------------
// hex_cell_corner_indices_top
// Corner vertex indices of one cell of a structured hexahedral grid.
// ----------------------------------------------------------------------------
// Pipeline: out_valid is registered through stages 1 to 3, the k and j
//   dividers, the stride products, the vertex base and the output register.
// Throughput: one cell index per clock while busy is low; busy falls out of reset and stays low.
// Results cannot be held off by the receiver; cfg_ready is always high.
// Reset (synchronous, active low) empties the pipeline and sets all axis
//   sizes to one.
module hex_cell_corner_indices_top
  import hcci_pkg::*;
#(
  parameter int MAX_CELLS_PER_AXIS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  logic [IDX_W-1:0]     in_cell_index,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // result channel
  output logic                 out_valid,
  output logic [CORNER_W-1:0]  out_corner_0,
  output logic [CORNER_W-1:0]  out_corner_1,
  output logic [CORNER_W-1:0]  out_corner_2,
  output logic [CORNER_W-1:0]  out_corner_3,
  output logic [CORNER_W-1:0]  out_corner_4,
  output logic [CORNER_W-1:0]  out_corner_5,
  output logic [CORNER_W-1:0]  out_corner_6,
  output logic [CORNER_W-1:0]  out_corner_7,
  output logic                 out_out_of_range
);

  localparam int QW  = $clog2(MAX_CELLS_PER_AXIS); // quotient bits for k and j
  localparam int AW  = QW + 1;                     // clamped axis size
  localparam int PW  = 2 * AW;                     // plane sizes
  localparam int TW  = 3 * AW;                     // total cell count
  localparam int OW  = (IDX_W > TW) ? IDX_W : TW;  // range compare width
  localparam int JRW = QW + AW;                    // j * row stride
  localparam int KPW = QW + PW;                    // k * plane stride

  typedef struct packed {
    logic          oor;
    logic [AW-1:0] ni;
    logic [AW-1:0] rowv;
    logic [PW-1:0] planev;
  } kside_t;

  typedef struct packed {
    logic          oor;
    logic [QW-1:0] k;
    logic [AW-1:0] rowv;
    logic [PW-1:0] planev;
  } jside_t;

  // configuration registers and accept logic
  logic [CFG_W-1:0] cells_i_r, cells_j_r, cells_k_r;
  logic             busy_r;
  logic             accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_i_r <= CFG_W'(1);
      cells_j_r <= CFG_W'(1);
      cells_k_r <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELLS_I: cells_i_r <= cfg_data;
        REG_CELLS_J: cells_j_r <= cfg_data;
        REG_CELLS_K: cells_k_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // busy only masks commands while reset holds the pipeline empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy_r;

  // stage 1: capture index and clamped axis sizes
  logic             s1_vld_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [AW-1:0]    s1_ni_r, s1_nj_r, s1_nk_r;
  // stage 2: cell and vertex plane sizes
  logic             s2_vld_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [AW-1:0]    s2_ni_r, s2_nk_r, s2_rowv_r;
  logic [PW-1:0]    s2_plane_r, s2_planev_r;
  // stage 3: total count
  logic             s3_vld_r;
  logic [IDX_W-1:0] s3_idx_r;
  logic [AW-1:0]    s3_ni_r, s3_rowv_r;
  logic [PW-1:0]    s3_plane_r, s3_planev_r;
  logic [TW-1:0]    s3_total_r;
  logic             s3_oor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r    <= in_cell_index;
    s1_ni_r     <= AW'(clamp_axis(cells_i_r, CFG_W'(MAX_CELLS_PER_AXIS)));
    s1_nj_r     <= AW'(clamp_axis(cells_j_r, CFG_W'(MAX_CELLS_PER_AXIS)));
    s1_nk_r     <= AW'(clamp_axis(cells_k_r, CFG_W'(MAX_CELLS_PER_AXIS)));

    s2_idx_r    <= s1_idx_r;
    s2_ni_r     <= s1_ni_r;
    s2_nk_r     <= s1_nk_r;
    s2_rowv_r   <= s1_ni_r + AW'(1);
    s2_plane_r  <= PW'(s1_ni_r) * PW'(s1_nj_r);
    s2_planev_r <= PW'(s1_ni_r + AW'(1)) * PW'(s1_nj_r + AW'(1));

    s3_idx_r    <= s2_idx_r;
    s3_ni_r     <= s2_ni_r;
    s3_rowv_r   <= s2_rowv_r;
    s3_plane_r  <= s2_plane_r;
    s3_planev_r <= s2_planev_r;
    s3_total_r  <= TW'(s2_plane_r) * TW'(s2_nk_r);
  end

  assign s3_oor = OW'(s3_idx_r) >= OW'(s3_total_r);

  // k = index / plane, remainder carries on to the row split
  logic             kd_vld;
  logic [QW-1:0]    kd_quo;
  logic [IDX_W-1:0] kd_rem;
  kside_t           kside_r [QW];

  hcci_div_pipe #(
    .NUM_W (IDX_W),
    .DEN_W (PW),
    .Q_W   (QW)
  ) u_div_k (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s3_vld_r),
    .in_num  (s3_idx_r),
    .in_den  (s3_plane_r),
    .out_vld (kd_vld),
    .out_quo (kd_quo),
    .out_rem (kd_rem)
  );

  always_ff @(posedge clk) begin
    kside_r[0] <= '{oor: s3_oor, ni: s3_ni_r, rowv: s3_rowv_r, planev: s3_planev_r};
    for (int n = 1; n < QW; n++) begin
      kside_r[n] <= kside_r[n-1];
    end
  end

  // j = remainder / ni, i is what is left
  logic          jd_vld;
  logic [QW-1:0] jd_quo;
  logic [PW-1:0] jd_rem;
  jside_t        jside_r [QW];
  kside_t        kside_out;

  assign kside_out = kside_r[QW-1];

  hcci_div_pipe #(
    .NUM_W (PW),
    .DEN_W (AW),
    .Q_W   (QW)
  ) u_div_j (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (kd_vld),
    .in_num  (PW'(kd_rem)),
    .in_den  (kside_out.ni),
    .out_vld (jd_vld),
    .out_quo (jd_quo),
    .out_rem (jd_rem)
  );

  always_ff @(posedge clk) begin
    jside_r[0] <= '{oor: kside_out.oor, k: kd_quo, rowv: kside_out.rowv,
                    planev: kside_out.planev};
    for (int n = 1; n < QW; n++) begin
      jside_r[n] <= jside_r[n-1];
    end
  end

  // stride products
  jside_t              jside_out;
  logic                m_vld_r;
  logic                m_oor_r;
  logic [AW-1:0]       m_i_r;
  logic [JRW-1:0]      m_jr_r;
  logic [KPW-1:0]      m_kp_r;
  logic [CORNER_W-1:0] m_rowv_r, m_pv_r, m_pvr_r;
  // vertex base
  logic                b_vld_r;
  logic                b_oor_r;
  logic [CORNER_W-1:0] b_base_r, b_rowv_r, b_pv_r, b_pvr_r;

  assign jside_out = jside_r[QW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      m_vld_r   <= jd_vld;
      b_vld_r   <= m_vld_r;
      out_valid <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_oor_r  <= jside_out.oor;
    m_i_r    <= AW'(jd_rem);
    m_jr_r   <= JRW'(jd_quo) * JRW'(jside_out.rowv);
    m_kp_r   <= KPW'(jside_out.k) * KPW'(jside_out.planev);
    m_rowv_r <= CORNER_W'(jside_out.rowv);
    m_pv_r   <= CORNER_W'(jside_out.planev);
    m_pvr_r  <= CORNER_W'(jside_out.planev) + CORNER_W'(jside_out.rowv);

    b_oor_r  <= m_oor_r;
    b_base_r <= CORNER_W'(m_i_r) + CORNER_W'(m_jr_r) + CORNER_W'(m_kp_r);
    b_rowv_r <= m_rowv_r;
    b_pv_r   <= m_pv_r;
    b_pvr_r  <= m_pvr_r;
  end

  // output register: eight corners, zeroed outside the grid
  always_ff @(posedge clk) begin
    out_out_of_range <= b_oor_r;
    if (b_oor_r) begin
      out_corner_0 <= '0;
      out_corner_1 <= '0;
      out_corner_2 <= '0;
      out_corner_3 <= '0;
      out_corner_4 <= '0;
      out_corner_5 <= '0;
      out_corner_6 <= '0;
      out_corner_7 <= '0;
    end else begin
      out_corner_0 <= b_base_r;
      out_corner_1 <= b_base_r + CORNER_W'(1);
      out_corner_2 <= b_base_r + b_rowv_r + CORNER_W'(1);
      out_corner_3 <= b_base_r + b_rowv_r;
      out_corner_4 <= b_base_r + b_pv_r;
      out_corner_5 <= b_base_r + b_pv_r + CORNER_W'(1);
      out_corner_6 <= b_base_r + b_pvr_r + CORNER_W'(1);
      out_corner_7 <= b_base_r + b_pvr_r;
    end
  end

endmodule

// File: design/hcci_port_checker.sv
// ----------------------------------------------------------------------------
// hcci_port_checker
// Port-level checks on the hex cell corner index block, bound to the top.
// ----------------------------------------------------------------------------
`include "hex_cell_corner_indices_top_macros.svh"

module hcci_port_checker
  import hcci_pkg::*;
#(
  parameter int MAX_CELLS_PER_AXIS = 1024
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [CORNER_W-1:0] out_corner_0,
  input logic [CORNER_W-1:0] out_corner_1,
  input logic [CORNER_W-1:0] out_corner_2,
  input logic [CORNER_W-1:0] out_corner_3,
  input logic [CORNER_W-1:0] out_corner_4,
  input logic [CORNER_W-1:0] out_corner_5,
  input logic [CORNER_W-1:0] out_corner_6,
  input logic [CORNER_W-1:0] out_corner_7,
  input logic                out_out_of_range
);

  // accepting edge to the edge that takes the result
  localparam int LATENCY = 2 * $clog2(MAX_CELLS_PER_AXIS) + 6;

  // every accepted transaction gives exactly one result, at fixed latency
  `HCCI_ASSERT_IMP(a_fixed_latency, clk, rst_n, 1'b1, out_valid == $past(start && !busy, LATENCY), "result strobe does not match accepted command")

  // once out of reset the pipeline never refuses a command
  `HCCI_ASSERT_NXT(a_never_busy, clk, rst_n, start && !busy, !busy, "busy rose after an accepted command")

  // a cell outside the grid reports all corners as zero
  `HCCI_ASSERT_IMP(a_oor_zero, clk, rst_n, out_valid && out_out_of_range, (out_corner_0 | out_corner_1 | out_corner_2 | out_corner_3 | out_corner_4 | out_corner_5 | out_corner_6 | out_corner_7) == '0, "out of range result has non-zero corners")

  // the i+1 corners sit one past their i neighbours, the two layers share strides
  `HCCI_ASSERT_IMP(a_corner_shape, clk, rst_n, out_valid && !out_out_of_range, (out_corner_1 == out_corner_0 + 1'b1) && (out_corner_2 == out_corner_3 + 1'b1) && (out_corner_5 == out_corner_4 + 1'b1) && (out_corner_6 == out_corner_7 + 1'b1) && ((out_corner_4 - out_corner_0) == (out_corner_7 - out_corner_3)), "corner set is not a unit hexahedron")

endmodule

bind hex_cell_corner_indices_top hcci_port_checker #(
  .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS)
) u_hcci_port_checker (.*);
